FILE: design/tgarle_pkg.sv
// Shared types and constants for the run-length TGA pixel decoder.
// Holds the decoder phase, error codes and the result word layout.
// No dependencies.
package tgarle_pkg;

	localparam int unsigned SPEC_BYTES = 6;
	localparam logic [7:0] DEPTH_RGB  = 8'd24;
	localparam logic [7:0] DEPTH_RGBA = 8'd32;
	localparam logic [7:0] RUN_FLAG   = 8'd128;
	localparam logic [7:0] RUN_BIAS   = 8'd127;

	typedef enum logic [1:0] {
		PH_SPEC,
		PH_PKT,
		PH_PIX,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_SPEC      = 2'd1,
		ERR_OVERSHOOT = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  run_length;
		logic [31:0] first_pixel_index;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        is_rgba;
		logic        image_done;
		err_code_t   error_code;
	} result_t;

	// Handshake between the input stage and the output register.
	typedef struct packed {
		logic fire;
	} flow_t;

endpackage

FILE: design/tgarle_in_stage.sv
// Input register of the TGA decoder: captures one stream word per cycle while not stalled.
// Depends on tgarle_pkg for the flow control struct.
module tgarle_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               frame_start,
	input  logic               advance,
	output tgarle_pkg::flow_t  flow,
	output logic [7:0]         byte_s1,
	output logic               start_s1
);
	import tgarle_pkg::*;

	logic valid_s1;
	logic load;

	assign in_stall     = valid_s1 && !advance;
	assign load         = in_valid && !in_stall;
	assign flow.fire    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1  <= in_byte;
			start_s1 <= frame_start;
		end
	end

endmodule

FILE: design/tgarle_decode.sv
// Decoder state and per-word logic: spec parsing, packet headers,
// pixel assembly and the pixel count check. Depends on tgarle_pkg.
module tgarle_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  tgarle_pkg::flow_t   flow,
	input  logic [7:0]          byte_s1,
	input  logic                start_s1,
	output logic                res_valid,
	output tgarle_pkg::result_t res
);
	import tgarle_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  spec_idx_q, spec_idx_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        rgba_q, rgba_d;
	logic        depth_ok_q, depth_ok_d;
	logic [31:0] total_q, total_d;
	logic [31:0] done_cnt_q, done_cnt_d;
	logic        is_run_q, is_run_d;
	logic [7:0]  remain_q, remain_d;
	logic [1:0]  col_idx_q, col_idx_d;
	logic [7:0]  hold_b_q, hold_b_d;
	logic [7:0]  hold_g_q, hold_g_d;
	logic [7:0]  hold_r_q, hold_r_d;

	phase_t      phase_eff;
	logic [2:0]  spec_idx_eff;
	logic [1:0]  last_idx;
	logic [7:0]  count;
	logic [32:0] end_cnt;
	logic        overshoot;
	logic [7:0]  remain_dec;
	logic [31:0] product;

	assign product = 32'(width_q) * 32'(height_q);

	always_comb begin
		// A frame start word behaves as if the decoder had just come out of reset.
		phase_eff    = start_s1 ? PH_SPEC : phase_q;
		spec_idx_eff = start_s1 ? 3'd0 : spec_idx_q;
		last_idx     = rgba_q ? 2'd3 : 2'd2;
		count        = is_run_q ? remain_q : 8'd1;
		end_cnt      = {1'b0, done_cnt_q} + 33'(count);
		overshoot    = end_cnt > {1'b0, total_q};
		remain_dec   = remain_q - 8'd1;

		phase_d    = phase_eff;
		spec_idx_d = spec_idx_eff;
		width_d    = width_q;
		height_d   = height_q;
		rgba_d     = rgba_q;
		depth_ok_d = depth_ok_q;
		total_d    = total_q;
		done_cnt_d = done_cnt_q;
		is_run_d   = is_run_q;
		remain_d   = remain_q;
		col_idx_d  = col_idx_q;
		hold_b_d   = hold_b_q;
		hold_g_d   = hold_g_q;
		hold_r_d   = hold_r_q;

		res_valid             = 1'b0;
		res.red               = 8'd0;
		res.green             = 8'd0;
		res.blue              = 8'd0;
		res.alpha             = 8'd0;
		res.run_length        = 8'd0;
		res.first_pixel_index = done_cnt_q;
		res.image_width       = width_q;
		res.image_height      = height_q;
		res.is_rgba           = rgba_q;
		res.image_done        = 1'b0;
		res.error_code        = ERR_NONE;

		case (phase_eff)
			PH_SPEC: begin
				case (spec_idx_eff)
					3'd0: width_d[7:0]   = byte_s1;
					3'd1: width_d[15:8]  = byte_s1;
					3'd2: height_d[7:0]  = byte_s1;
					3'd3: height_d[15:8] = byte_s1;
					3'd4: begin
						depth_ok_d = (byte_s1 == DEPTH_RGB) || (byte_s1 == DEPTH_RGBA);
						rgba_d     = byte_s1 == DEPTH_RGBA;
					end
					default: ;
				endcase
				if (spec_idx_eff < 3'(SPEC_BYTES - 1)) begin
					spec_idx_d = spec_idx_eff + 3'd1;
				end else begin
					spec_idx_d = 3'd0;
					if (width_q == 16'd0 || height_q == 16'd0 || !depth_ok_q) begin
						phase_d               = PH_HALT;
						res_valid             = 1'b1;
						res.first_pixel_index = 32'd0;
						res.image_done        = 1'b1;
						res.error_code        = ERR_SPEC;
					end else begin
						total_d    = product;
						done_cnt_d = 32'd0;
						phase_d    = PH_PKT;
					end
				end
			end
			PH_PKT: begin
				if (byte_s1 < RUN_FLAG) begin
					is_run_d = 1'b0;
					remain_d = byte_s1 + 8'd1;
				end else begin
					is_run_d = 1'b1;
					remain_d = byte_s1 - RUN_BIAS;
				end
				col_idx_d = 2'd0;
				phase_d   = PH_PIX;
			end
			PH_PIX: begin
				case (col_idx_q)
					2'd0: hold_b_d = byte_s1;
					2'd1: hold_g_d = byte_s1;
					2'd2: hold_r_d = byte_s1;
					default: ;
				endcase
				if (col_idx_q != last_idx) begin
					col_idx_d = col_idx_q + 2'd1;
				end else begin
					col_idx_d      = 2'd0;
					res_valid      = 1'b1;
					if (overshoot) begin
						phase_d        = PH_HALT;
						res.image_done = 1'b1;
						res.error_code = ERR_OVERSHOOT;
					end else begin
						done_cnt_d     = end_cnt[31:0];
						res.blue       = hold_b_q;
						res.green      = hold_g_q;
						res.red        = (col_idx_q == 2'd2) ? byte_s1 : hold_r_q;
						res.alpha      = rgba_q ? byte_s1 : 8'd0;
						res.run_length = count;
						if (is_run_q) begin
							remain_d = 8'd0;
						end else begin
							remain_d = remain_dec;
						end
						if (is_run_q || remain_dec == 8'd0) begin
							if (end_cnt[31:0] == total_q) begin
								res.image_done = 1'b1;
								phase_d        = PH_HALT;
							end else begin
								phase_d = PH_PKT;
							end
						end
					end
				end
			end
			default: ;
		endcase

		if (!flow.fire) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SPEC;
			spec_idx_q <= 3'd0;
			width_q    <= 16'd0;
			height_q   <= 16'd0;
			rgba_q     <= 1'b0;
			depth_ok_q <= 1'b0;
			total_q    <= 32'd0;
			done_cnt_q <= 32'd0;
			is_run_q   <= 1'b0;
			remain_q   <= 8'd0;
			col_idx_q  <= 2'd0;
		end else if (flow.fire) begin
			phase_q    <= phase_d;
			spec_idx_q <= spec_idx_d;
			width_q    <= width_d;
			height_q   <= height_d;
			rgba_q     <= rgba_d;
			depth_ok_q <= depth_ok_d;
			total_q    <= total_d;
			done_cnt_q <= done_cnt_d;
			is_run_q   <= is_run_d;
			remain_q   <= remain_d;
			col_idx_q  <= col_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.fire) begin
			hold_b_q <= hold_b_d;
			hold_g_q <= hold_g_d;
			hold_r_q <= hold_r_d;
		end
	end

endmodule

FILE: design/tgarle_out_reg.sv
// Result register of the TGA decoder, holding one word for the output channel.
// Depends on tgarle_pkg for the result layout.
module tgarle_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  tgarle_pkg::flow_t   flow,
	input  logic                res_valid,
	input  tgarle_pkg::result_t res,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_stall,
	output tgarle_pkg::result_t res_q
);
	import tgarle_pkg::*;

	logic valid_q;

	assign advance   = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flow.fire && res_valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.fire && res_valid) begin
			res_q <= res;
		end
	end

endmodule

FILE: design/tga_rle_pixel_decoder_core.sv
// Top level of the run-length TGA pixel decoder.
// Depends on tgarle_pkg, tgarle_in_stage, tgarle_decode and tgarle_out_reg.
//
// The decoder takes one byte of a run-length coded TGA stream per clock cycle when
// not stalled and gives at most one result word per byte: a literal pixel with run
// length one, or a whole run with its pixel and count, so a downstream writer does
// the expansion. A byte passes the input register, and its result is then written
// into the output register; the throughput is one byte per cycle while the output
// is not stalled, since each byte only updates small counters and registers in a
// single pass through the decode logic. A stalled output register still lets one
// further byte into the input register. Errors (bad spec or too many pixels) end the
// image with image_done set; later bytes are dropped until one has frame_start set.
module tga_rle_pixel_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [7:0]  run_length,
	output logic [31:0] first_pixel_index,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        is_rgba,
	output logic        image_done,
	output logic [1:0]  error_code
);
	import tgarle_pkg::*;

	flow_t      flow;
	logic       advance;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	tgarle_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.frame_start(frame_start),
		.advance    (advance),
		.flow       (flow),
		.byte_s1    (byte_s1),
		.start_s1   (start_s1)
	);

	tgarle_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.flow     (flow),
		.byte_s1  (byte_s1),
		.start_s1 (start_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	tgarle_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.flow     (flow),
		.res_valid(res_valid),
		.res      (res),
		.advance  (advance),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res_q    (res_q)
	);

	assign red               = res_q.red;
	assign green             = res_q.green;
	assign blue              = res_q.blue;
	assign alpha             = res_q.alpha;
	assign run_length        = res_q.run_length;
	assign first_pixel_index = res_q.first_pixel_index;
	assign image_width       = res_q.image_width;
	assign image_height      = res_q.image_height;
	assign is_rgba           = res_q.is_rgba;
	assign image_done        = res_q.image_done;
	assign error_code        = res_q.error_code;

	// Any error word closes the image.
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_q.error_code != ERR_NONE) |-> res_q.image_done)
		else $error("error word without image_done");

	// A good pixel word always covers at least one pixel.
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_q.error_code == ERR_NONE) |-> (res_q.run_length != 8'd0))
		else $error("pixel word with zero run length");

	// The input side only stalls while the input register holds a word that cannot move.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with a free output register");

	// A result is only produced from a word that moved out of the input register.
	a_res_from_fire: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> flow.fire)
		else $error("result raised without an advancing word");

endmodule
